FILE: rtl/core/hsvd_pkg.sv
// hsvd_pkg: shared constants, sector codes and stage payload types for the
// HSV to RGB duty converter. No dependencies.
package hsvd_pkg;

  localparam int FRAC_BITS = 12;              // fixed point: 1.0 = 2^FRAC_BITS
  localparam int DUTY_BITS = 13;              // full duty = 2^DUTY_BITS - 1
  localparam int HUE_W     = 9;
  localparam int FX_W      = FRAC_BITS + 1;   // saturation / brightness
  localparam int DUTY_W    = DUTY_BITS;
  localparam int PROD_W    = 2 * FRAC_BITS + 1; // v*s and v*ONE, up to 2^24
  localparam int SCL_W     = PROD_W + DUTY_BITS;
  localparam int T_W       = 6;               // ramp position 0..60
  localparam int REM_W     = 6;               // remainder mod 60
  localparam int QV_W      = 19;              // (v*s)/60
  localparam int W_W       = 12;              // t * remainder, up to 3540
  localparam int NSTG      = 6;               // register stages, input to output

  localparam logic [FX_W-1:0]  ONE_FX     = FX_W'(1) << FRAC_BITS;
  localparam logic [HUE_W-1:0] DEG_TURN   = HUE_W'(360);
  localparam logic [HUE_W-1:0] DEG_120    = HUE_W'(120);
  localparam logic [HUE_W-1:0] DEG_180    = HUE_W'(180);
  localparam logic [HUE_W-1:0] DEG_240    = HUE_W'(240);
  localparam logic [HUE_W-1:0] DEG_300    = HUE_W'(300);
  localparam logic [HUE_W-1:0] DEG_SECTOR = HUE_W'(60);

  // floor(x/15) = (x * REC15) >> REC15_SH, exact for x < 2^23
  localparam int               REC15_SH = 27;
  localparam logic [23:0]      REC15    = 24'd8947849;
  // floor(x/60) = (x * REC60) >> REC60_SH, exact for x <= 3540
  localparam int               REC60_SH = 17;
  localparam logic [11:0]      REC60    = 12'd2185;
  // full duty = 60 * DUTY_X_INT + DUTY_X_FRAC
  localparam int               DUTY_X_INT  = 136;
  localparam int               DUTY_X_FRAC = 31;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [PROD_W-1:0] vs;
    logic [FX_W-1:0]   v;
    sector_t           sector;
    logic [T_W-1:0]    t;
  } s1_t;

  typedef struct packed {
    logic [PROD_W-1:0] vs;
    logic [PROD_W-1:0] mres;
    logic [FX_W-1:0]   v;
    sector_t           sector;
    logic [T_W-1:0]    t;
    logic [QV_W-1:0]   qv;
  } s2_t;

  typedef struct packed {
    logic [PROD_W-1:0] mres;
    logic [FX_W-1:0]   v;
    sector_t           sector;
    logic [PROD_W-1:0] tq;
    logic [W_W-1:0]    w;
  } s3_t;

  typedef struct packed {
    logic [PROD_W-1:0] mres;
    logic [FX_W-1:0]   v;
    sector_t           sector;
    logic [PROD_W-1:0] ysum;
    logic [REM_W-1:0]  rw;
  } s4_t;

  typedef struct packed {
    logic [PROD_W-1:0] mres;
    logic [FX_W-1:0]   v;
    sector_t           sector;
    logic [PROD_W-1:0] ysum;
    logic [DUTY_W-1:0] fr;
  } s5_t;

endpackage

FILE: rtl/core/hsvd_if.sv
// hsvd_if: valid/ready channels for HSV items in and duty items out.
// Depends on hsvd_pkg for field widths.
interface hsvd_in_if;
  logic                         valid;
  logic                         ready;
  logic [hsvd_pkg::HUE_W-1:0]   hue;
  logic [hsvd_pkg::FX_W-1:0]    saturation;
  logic [hsvd_pkg::FX_W-1:0]    brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvd_out_if;
  logic                         valid;
  logic                         ready;
  logic [hsvd_pkg::DUTY_W-1:0]  red_duty;
  logic [hsvd_pkg::DUTY_W-1:0]  green_duty;
  logic [hsvd_pkg::DUTY_W-1:0]  blue_duty;

  modport source (output valid, red_duty, green_duty, blue_duty, input ready);
  modport sink   (input valid, red_duty, green_duty, blue_duty, output ready);
endinterface

FILE: rtl/core/hsvd_front.sv
// hsvd_front: first stage. Clamps saturation and brightness, wraps the hue,
// finds the sector and ramp position, and forms chroma v*s. Uses hsvd_pkg.
module hsvd_front (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hsvd_pkg::HUE_W-1:0]   hue,
  input  logic [hsvd_pkg::FX_W-1:0]    saturation,
  input  logic [hsvd_pkg::FX_W-1:0]    brightness,
  output hsvd_pkg::s1_t                st_r
);
  import hsvd_pkg::*;

  logic [FX_W-1:0]    sat_c;
  logic [FX_W-1:0]    bri_c;
  logic [HUE_W-1:0]   h;
  logic [HUE_W-1:0]   base;
  logic [HUE_W-1:0]   pos9;
  logic [T_W-1:0]     pos;
  sector_t            sec;
  logic [2*FX_W-1:0]  prod;
  s1_t                st_nxt;

  always_comb begin
    sat_c = (saturation > ONE_FX) ? ONE_FX : saturation;
    bri_c = (brightness > ONE_FX) ? ONE_FX : brightness;
    h     = (hue >= DEG_TURN) ? (hue - DEG_TURN) : hue;

    if (h >= DEG_300) begin
      sec = SEC_MAG_RED; base = DEG_300;
    end else if (h >= DEG_240) begin
      sec = SEC_BLU_MAG; base = DEG_240;
    end else if (h >= DEG_180) begin
      sec = SEC_CYN_BLU; base = DEG_180;
    end else if (h >= DEG_120) begin
      sec = SEC_GRN_CYN; base = DEG_120;
    end else if (h >= DEG_SECTOR) begin
      sec = SEC_YEL_GRN; base = DEG_SECTOR;
    end else begin
      sec = SEC_RED_YEL; base = '0;
    end

    pos9 = h - base;
    pos  = pos9[T_W-1:0];
    prod = {{FX_W{1'b0}}, sat_c} * {{FX_W{1'b0}}, bri_c};

    st_nxt.vs     = prod[PROD_W-1:0];
    st_nxt.v      = bri_c;
    st_nxt.sector = sec;
    // falling ramp in odd sectors
    st_nxt.t      = sec[0] ? (DEG_SECTOR[T_W-1:0] - pos) : pos;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: rtl/core/hsvd_div.sv
// hsvd_div: stages two to five. Splits the ramp term t*v*s/60 into whole and
// remainder parts with reciprocal multiplies. Uses hsvd_pkg.
module hsvd_div (
  input  logic            clk,
  input  logic [3:0]      en,
  input  hsvd_pkg::s1_t   s1,
  output hsvd_pkg::s5_t   s5_r
);
  import hsvd_pkg::*;

  s2_t                  s2_r, s2_nxt;
  s3_t                  s3_r, s3_nxt;
  s4_t                  s4_r, s4_nxt;
  s5_t                  s5_nxt;

  logic [PROD_W-3:0]    vq;
  logic [PROD_W+21:0]   rec_prod;
  logic [PROD_W-1:0]    qv60;
  logic [PROD_W-1:0]    rv_full;
  logic [REM_W-1:0]     rv;
  logic [PROD_W-1:0]    tq_prod;
  logic [W_W-1:0]       w_prod;
  logic [2*W_W-1:0]     qw_prod;
  logic [REM_W-1:0]     qw;
  logic [W_W-1:0]       qw60;
  logic [W_W-1:0]       rw_full;
  logic [10:0]          fr_lo;
  logic [22:0]          fr_prod;
  logic [DUTY_W-1:0]    fr_int;

  // stage 2: q = floor(v*s / 60) = floor((v*s >> 2) / 15); offset m = v*ONE - v*s
  always_comb begin
    vq       = s1.vs[PROD_W-1:2];
    rec_prod = {{24{1'b0}}, vq} * {{(PROD_W-2){1'b0}}, REC15};
    s2_nxt.vs     = s1.vs;
    s2_nxt.mres   = {s1.v, {FRAC_BITS{1'b0}}} - s1.vs;
    s2_nxt.v      = s1.v;
    s2_nxt.sector = s1.sector;
    s2_nxt.t      = s1.t;
    s2_nxt.qv     = rec_prod[REC15_SH +: QV_W];
  end

  // stage 3: remainder of v*s, then t*q and t*remainder
  always_comb begin
    qv60    = {s2_r.qv, 6'b0} - {4'b0, s2_r.qv, 2'b0};
    rv_full = s2_r.vs - qv60;
    rv      = rv_full[REM_W-1:0];
    tq_prod = {{(PROD_W-T_W){1'b0}}, s2_r.t} * {{(PROD_W-QV_W){1'b0}}, s2_r.qv};
    w_prod  = {{(W_W-T_W){1'b0}}, s2_r.t} * {{(W_W-REM_W){1'b0}}, rv};
    s3_nxt.mres   = s2_r.mres;
    s3_nxt.v      = s2_r.v;
    s3_nxt.sector = s2_r.sector;
    s3_nxt.tq     = tq_prod;
    s3_nxt.w      = w_prod;
  end

  // stage 4: split t*remainder by 60, sum whole parts with the offset
  always_comb begin
    qw_prod = {{W_W{1'b0}}, s3_r.w} * {{W_W{1'b0}}, REC60};
    qw      = qw_prod[REC60_SH +: REM_W];
    qw60    = {qw, 6'b0} - {4'b0, qw, 2'b0};
    rw_full = s3_r.w - qw60;
    s4_nxt.mres   = s3_r.mres;
    s4_nxt.v      = s3_r.v;
    s4_nxt.sector = s3_r.sector;
    s4_nxt.ysum   = s3_r.mres + s3_r.tq + {{(PROD_W-REM_W){1'b0}}, qw};
    s4_nxt.rw     = rw_full[REM_W-1:0];
  end

  // stage 5: floor(full duty * rw / 60), with full duty = 60*136 + 31
  always_comb begin
    fr_lo   = 11'(DUTY_X_FRAC) * {5'b0, s4_r.rw};
    fr_prod = {12'b0, fr_lo} * {11'b0, REC60};
    fr_int  = 13'(DUTY_X_INT) * {7'b0, s4_r.rw};
    s5_nxt.mres   = s4_r.mres;
    s5_nxt.v      = s4_r.v;
    s5_nxt.sector = s4_r.sector;
    s5_nxt.ysum   = s4_r.ysum;
    s5_nxt.fr     = fr_int + {{(DUTY_W-5){1'b0}}, fr_prod[REC60_SH +: 5]};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s2_r <= s2_nxt;
    end
    if (en[1]) begin
      s3_r <= s3_nxt;
    end
    if (en[2]) begin
      s4_r <= s4_nxt;
    end
    if (en[3]) begin
      s5_r <= s5_nxt;
    end
  end

endmodule

FILE: rtl/core/hsvd_scale.sv
// hsvd_scale: last stage. Scales chroma, ramp and offset channels to the
// full duty, truncates, and places them by sector. Uses hsvd_pkg.
module hsvd_scale (
  input  logic                         clk,
  input  logic                         en,
  input  hsvd_pkg::s5_t                s5,
  output logic [hsvd_pkg::DUTY_W-1:0]  red_r,
  output logic [hsvd_pkg::DUTY_W-1:0]  green_r,
  output logic [hsvd_pkg::DUTY_W-1:0]  blue_r
);
  import hsvd_pkg::*;

  logic [DUTY_W-1:0] cd;
  logic [DUTY_W-1:0] xd;
  logic [DUTY_W-1:0] md;
  logic [DUTY_W-1:0] red_nxt, green_nxt, blue_nxt;

  // floor((u * full_duty + f) / ONE^2), full duty multiply as shift-subtract
  function automatic logic [DUTY_W-1:0] to_duty(input logic [PROD_W-1:0] u,
                                                input logic [DUTY_W-1:0] f);
    logic [SCL_W-1:0] acc;
    acc = {u, {DUTY_BITS{1'b0}}} - {{DUTY_BITS{1'b0}}, u} + {{PROD_W{1'b0}}, f};
    return acc[2*FRAC_BITS +: DUTY_W];
  endfunction

  always_comb begin
    cd = to_duty({s5.v, {FRAC_BITS{1'b0}}}, '0);
    xd = to_duty(s5.ysum, s5.fr);
    md = to_duty(s5.mres, '0);

    case (s5.sector)
      SEC_RED_YEL: begin red_nxt = cd; green_nxt = xd; blue_nxt = md; end
      SEC_YEL_GRN: begin red_nxt = xd; green_nxt = cd; blue_nxt = md; end
      SEC_GRN_CYN: begin red_nxt = md; green_nxt = cd; blue_nxt = xd; end
      SEC_CYN_BLU: begin red_nxt = md; green_nxt = xd; blue_nxt = cd; end
      SEC_BLU_MAG: begin red_nxt = xd; green_nxt = md; blue_nxt = cd; end
      default: begin red_nxt = cd; green_nxt = md; blue_nxt = xd; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

endmodule

FILE: rtl/core/hsv_to_rgb_duty.sv
// HSV to RGB duty converter. Takes one item per clock while input ready is
// high and returns one result per item. Each item passes through the six
// register stages (clamp and v*s, reciprocal divide by 60, remainder products,
// remainder split, fraction, scale and place). Each stage holds its own valid
// bit and fills a bubble even while the output waits, so input ready stays
// high as long as any stage is empty. Hue 360..511 wraps once, saturation and
// brightness above 4096 clamp to 4096.
module hsv_to_rgb_duty (
  input  logic        clk,
  input  logic        rst_n,
  hsvd_in_if.sink     in_ch,
  hsvd_out_if.source  out_ch
);
  import hsvd_pkg::*;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;
  logic [NSTG-1:0] dn_rdy;
  s1_t             s1_r;
  s5_t             s5_r;

  always_comb begin
    rdy[NSTG-1]    = !vld_r[NSTG-1] || out_ch.ready;
    dn_rdy[NSTG-1] = out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i]    = !vld_r[i] || rdy[i+1];
      dn_rdy[i] = rdy[i+1];
    end
    ld[0] = in_ch.valid && rdy[0];
    for (int i = 1; i < NSTG; i++) begin
      ld[i] = vld_r[i-1] && rdy[i];
    end
    // load a new item, or hold one that downstream did not take
    vld_nxt = ld | (vld_r & ~dn_rdy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = vld_r[NSTG-1];

  hsvd_front u_front (
    .clk        (clk),
    .en         (ld[0]),
    .hue        (in_ch.hue),
    .saturation (in_ch.saturation),
    .brightness (in_ch.brightness),
    .st_r       (s1_r)
  );

  hsvd_div u_div (
    .clk  (clk),
    .en   (ld[4:1]),
    .s1   (s1_r),
    .s5_r (s5_r)
  );

  hsvd_scale u_scale (
    .clk     (clk),
    .en      (ld[NSTG-1]),
    .s5      (s5_r),
    .red_r   (out_ch.red_duty),
    .green_r (out_ch.green_duty),
    .blue_r  (out_ch.blue_duty)
  );

  // any empty stage lets an item in
  a_ready_on_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r != {NSTG{1'b1}}) |-> in_ch.ready)
    else $error("input stalled with an empty stage");

  // an item entering an empty pipeline reaches the output after six stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (ld[0] && (vld_r == '0)) |-> ##6 out_ch.valid)
    else $error("item lost or late in the pipeline");

  // the output stage never empties while its item is unconsumed
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-1] && !out_ch.ready) |=> vld_r[NSTG-1])
    else $error("output item dropped under stall");

endmodule

FILE: tb/sv/tb_hsv_to_rgb_duty.sv
// tb_hsv_to_rgb_duty: self-checking bench for the HSV to RGB duty converter.
// Drives directed and random HSV items, predicts each duty item in SV and
// compares it in order. Depends on hsvd_pkg, hsvd_if and hsv_to_rgb_duty.
`timescale 1ns / 100ps

module tb_hsv_to_rgb_duty;
  import hsvd_pkg::*;

  localparam int          CLK_PERIOD  = 12;
  localparam int          RESET_CYC   = 7;
  localparam int          PHASE_ITEMS = 600;
  localparam int          HOLD_CYC    = 200;
  localparam int          DRAIN_CYC   = 3 * NSTG;
  localparam int          N_DIRECTED  = 25;
  localparam longint unsigned DUTY_FULL = (64'd1 << DUTY_BITS) - 1;

  typedef struct packed {
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
  } duty_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [FX_W-1:0]  sat;
    logic [FX_W-1:0]  bri;
    logic             known;
    duty_t            duty;
  } stim_row_t;

  logic clk;
  logic rst_n;

  hsvd_in_if  in_ch ();
  hsvd_out_if out_ch ();

  hsv_to_rgb_duty u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  duty_t pending_duties[$];
  int    fail_count    = 0;
  int    src_idle_pct  = 0;
  int    snk_idle_pct  = 0;
  int    hold_requests = 0;
  int    holds_served  = 0;
  int    hold_left     = 0;

  // Known rows: black, white, primaries and secondaries at sector starts,
  // hue wrap and clamping of saturation and brightness.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{9'd0,   13'd4096, 13'd0,    1'b1, '{13'd0,    13'd0,    13'd0}},
    '{9'd0,   13'd0,    13'd4096, 1'b1, '{13'd8191, 13'd8191, 13'd8191}},
    '{9'd0,   13'd4096, 13'd4096, 1'b1, '{13'd8191, 13'd0,    13'd0}},
    '{9'd60,  13'd4096, 13'd4096, 1'b1, '{13'd8191, 13'd8191, 13'd0}},
    '{9'd120, 13'd4096, 13'd4096, 1'b1, '{13'd0,    13'd8191, 13'd0}},
    '{9'd180, 13'd4096, 13'd4096, 1'b1, '{13'd0,    13'd8191, 13'd8191}},
    '{9'd240, 13'd4096, 13'd4096, 1'b1, '{13'd0,    13'd0,    13'd8191}},
    '{9'd300, 13'd4096, 13'd4096, 1'b1, '{13'd8191, 13'd0,    13'd8191}},
    '{9'd360, 13'd4096, 13'd4096, 1'b1, '{13'd8191, 13'd0,    13'd0}},
    '{9'd420, 13'd4097, 13'd4097, 1'b1, '{13'd8191, 13'd8191, 13'd0}},
    '{9'd120, 13'd8191, 13'd4096, 1'b1, '{13'd0,    13'd8191, 13'd0}},
    '{9'd240, 13'd4096, 13'd8191, 1'b1, '{13'd0,    13'd0,    13'd8191}},
    '{9'd0,   13'd8191, 13'd8191, 1'b1, '{13'd8191, 13'd0,    13'd0}},
    '{9'd0,   13'd0,    13'd8191, 1'b1, '{13'd8191, 13'd8191, 13'd8191}},
    '{9'd511, 13'd8191, 13'd0,    1'b1, '{13'd0,    13'd0,    13'd0}},
    '{9'd511, 13'd3000, 13'd3500, 1'b0, '0},
    '{9'd30,  13'd2048, 13'd3000, 1'b0, '0},
    '{9'd90,  13'd2048, 13'd3000, 1'b0, '0},
    '{9'd150, 13'd2048, 13'd3000, 1'b0, '0},
    '{9'd210, 13'd2048, 13'd3000, 1'b0, '0},
    '{9'd270, 13'd2048, 13'd3000, 1'b0, '0},
    '{9'd330, 13'd2048, 13'd3000, 1'b0, '0},
    '{9'd359, 13'd4096, 13'd4096, 1'b0, '0},
    '{9'd59,  13'd1,    13'd1,    1'b0, '0},
    '{9'd1,   13'd4095, 13'd4095, 1'b0, '0}
  };

  function automatic logic [DUTY_W-1:0] scale_duty(longint unsigned num);
    return DUTY_W'(((num * DUTY_FULL) / longint'(DEG_SECTOR)) >> (2 * FRAC_BITS));
  endfunction

  function automatic duty_t hsv_duty_of(logic [HUE_W-1:0] hue, logic [FX_W-1:0] sat,
                                        logic [FX_W-1:0] bri);
    logic [HUE_W-1:0] h;
    sector_t          sec;
    int unsigned      pos, t;
    longint unsigned  s, v, cn, xn, mn, rn, gn, bn;
    duty_t            d;
    h   = (hue >= DEG_TURN) ? hue - DEG_TURN : hue;
    s   = (sat > ONE_FX) ? ONE_FX : sat;
    v   = (bri > ONE_FX) ? ONE_FX : bri;
    sec = sector_t'(h / DEG_SECTOR);
    pos = h - sec * DEG_SECTOR;
    t   = sec[0] ? DEG_SECTOR - pos : pos;
    // every term is scaled by 60 * ONE * ONE
    cn  = v * s * DEG_SECTOR;
    xn  = v * s * t;
    mn  = v * ONE_FX * DEG_SECTOR - cn;
    case (sec)
      SEC_RED_YEL: begin rn = cn; gn = xn; bn = 0;  end
      SEC_YEL_GRN: begin rn = xn; gn = cn; bn = 0;  end
      SEC_GRN_CYN: begin rn = 0;  gn = cn; bn = xn; end
      SEC_CYN_BLU: begin rn = 0;  gn = xn; bn = cn; end
      SEC_BLU_MAG: begin rn = xn; gn = 0;  bn = cn; end
      default:     begin rn = cn; gn = 0;  bn = xn; end
    endcase
    d.red   = scale_duty(rn + mn);
    d.green = scale_duty(gn + mn);
    d.blue  = scale_duty(bn + mn);
    return d;
  endfunction

  function automatic logic [FX_W-1:0] rand_fx();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8)  return ONE_FX;
    if (pick < 14) return '0;
    if (pick < 26) return FX_W'($urandom_range(8191, 4097));
    return FX_W'($urandom_range(4096));
  endfunction

  function automatic logic [HUE_W-1:0] rand_hue();
    if ($urandom_range(99) < 12) return HUE_W'($urandom_range(511, 360));
    return HUE_W'($urandom_range(359));
  endfunction

  // Offer one item, hold it until accepted, then queue its expected duties.
  task automatic send_hsv(input logic [HUE_W-1:0] hue, input logic [FX_W-1:0] sat,
                          input logic [FX_W-1:0] bri, input logic known,
                          input duty_t typed_duty);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.hue        <= hue;
    in_ch.saturation <= sat;
    in_ch.brightness <= bri;
    do @(posedge clk); while (!in_ch.ready);
    pending_duties.push_back(known ? typed_duty : hsv_duty_of(hue, sat, bri));
  endtask

  task automatic send_random(input int count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_requests <= hold_requests + 1;
      send_hsv(rand_hue(), rand_fx(), rand_fx(), 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Duty sink: check each accepted item and drive ready, with a long hold on request.
  initial begin : duty_sink
    duty_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_duties.size() == 0) begin
          $error("duty item with no expectation: r=%0d g=%0d b=%0d",
                 out_ch.red_duty, out_ch.green_duty, out_ch.blue_duty);
          fail_count++;
        end else begin
          want = pending_duties.pop_front();
          if (out_ch.red_duty !== want.red) begin
            $error("red_duty: expected %0d, got %0d", want.red, out_ch.red_duty);
            fail_count++;
          end
          if (out_ch.green_duty !== want.green) begin
            $error("green_duty: expected %0d, got %0d", want.green, out_ch.green_duty);
            fail_count++;
          end
          if (out_ch.blue_duty !== want.blue) begin
            $error("blue_duty: expected %0d, got %0d", want.blue, out_ch.blue_duty);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYC;
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin : stimulus
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.hue        <= '0;
    in_ch.saturation <= '0;
    in_ch.brightness <= '0;
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 31;
    snk_idle_pct = 77;
    foreach (directed_rows[i])
      send_hsv(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].bri,
               directed_rows[i].known, directed_rows[i].duty);
    send_random(PHASE_ITEMS, -1);

    src_idle_pct = 77;
    snk_idle_pct = 31;
    send_random(PHASE_ITEMS, -1);

    // no idling; the sink holds off after item 100 so the pipe fills and stalls input
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random(PHASE_ITEMS, 100);
    in_ch.valid <= 1'b0;

    while (pending_duties.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: hsv_to_rgb_duty.f
rtl/core/hsvd_pkg.sv
rtl/core/hsvd_if.sv
rtl/core/hsvd_front.sv
rtl/core/hsvd_div.sv
rtl/core/hsvd_scale.sv
rtl/core/hsv_to_rgb_duty.sv
tb/sv/tb_hsv_to_rgb_duty.sv
